FILE: rtl/core/pfs_pkg.sv
// Shared types, widths and constants of the pixel frame statistics block.
// No dependencies; used by every module under rtl/core.
`default_nettype none
package pfs_pkg;

  localparam int COUNT_BITS = 24;
  localparam int PIX_W      = 16;
  localparam int F24_W      = 24;
  localparam int SUM_W      = COUNT_BITS + 16;
  localparam int SQ_W       = COUNT_BITS + 32;
  localparam int QUOT_W     = 48;
  localparam int DIVD_W     = COUNT_BITS + QUOT_W;
  localparam int QCNT_W     = $clog2(QUOT_W);
  localparam int ROOT_W     = 24;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int RCNT_W     = $clog2(ROOT_W);

  localparam logic [PIX_W-1:0]      THR_RESET = 16'd65530;
  localparam logic [PIX_W-1:0]      PIX_MAX   = 16'd65535;
  localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

  typedef struct packed {
    logic [SUM_W-1:0]      sum;
    logic [SQ_W-1:0]       sq;
    logic [PIX_W-1:0]      max_v;
    logic [PIX_W-1:0]      min_v;
    logic [COUNT_BITS-1:0] ovl;
    logic [COUNT_BITS-1:0] tally;
    logic                  ovf;
  } frame_t;

  localparam frame_t FRAME_CLEAR = '{
    sum:   '0,
    sq:    '0,
    max_v: '0,
    min_v: PIX_MAX,
    ovl:   '0,
    tally: '0,
    ovf:   1'b0
  };

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [F24_W-1:0] fit24(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+F24_W-1:0] w;
    w = {{F24_W{1'b0}}, v};
    return w[F24_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pixel_frame_statistics.sv
// Pixel frame statistics: per-frame mean, deviation, extremes and counts.
// Top level; depends on pfs_pkg, pfs_accum, pfs_div and pfs_sqrt.
//
// Input channel (in_valid/in_ready, pixel, last): one pixel request per cycle while in_ready is high.
// The pixel flagged last closes the frame and is included in it.
// Output channel (out_valid/out_ready): one result request per frame, held
// in an output register until taken.
// cfg_write/cfg_data load the overload threshold (reset value 65530).
// From acceptance of the last pixel to out_valid the frame passes through two
// 48-step passes of the serial divider (mean, then scaled sum of squares), 24
// steps of the serial root and the sequencer states.
// Throughput: one pixel per cycle while in_ready is high. A last pixel waits in
// stage 1 while the previous frame is still in the finisher, and in_ready stays
// low meanwhile, so no further pixels are taken until the finisher takes it.
// A stalled receiver holds the result; the finisher then waits with the
// next frame's result until the output register frees up.
// Reset (rst, synchronous) clears accumulators, sequencer and out_valid and
// restores the threshold.
`default_nettype none
module pixel_frame_statistics (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [pfs_pkg::PIX_W-1:0]  cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [pfs_pkg::PIX_W-1:0]  pixel,
  input  wire logic                       last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [pfs_pkg::F24_W-1:0]       mean_q8,
  output logic [pfs_pkg::F24_W-1:0]       stddev_q8,
  output logic [pfs_pkg::PIX_W-1:0]       max_value,
  output logic [pfs_pkg::PIX_W-1:0]       min_value,
  output logic [pfs_pkg::F24_W-1:0]       overload_count,
  output logic [pfs_pkg::F24_W-1:0]       pixel_count,
  output logic                            count_overflow
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_SC_WAIT,
    ST_SQUARE,
    ST_DIFF,
    ST_ROOT_WAIT,
    ST_HOLD
  } state_t;

  state_t                        state;
  logic                          fin_busy;
  logic                          frame_start;
  pfs_pkg::frame_t               frame;
  pfs_pkg::frame_t               fr;
  logic                          div_start;
  logic [pfs_pkg::DIVD_W-1:0]    div_numer;
  logic [pfs_pkg::DIVD_W-1:0]    d_mean;
  logic [pfs_pkg::DIVD_W-1:0]    d_scaled;
  logic [pfs_pkg::QUOT_W-1:0]    div_quot;
  pfs_pkg::unit_stat_t           div_stat;
  logic                          sqrt_start;
  logic [pfs_pkg::RAD_W-1:0]     radicand;
  logic [pfs_pkg::ROOT_W-1:0]    root;
  pfs_pkg::unit_stat_t           sqrt_stat;
  logic [pfs_pkg::F24_W-1:0]     mean_r;
  logic [pfs_pkg::ROOT_W-1:0]    sd;
  logic [pfs_pkg::RAD_W-1:0]     scaled;
  logic [pfs_pkg::RAD_W-1:0]     msq;
  logic [pfs_pkg::RAD_W-1:0]     mean_sq;

  pfs_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .last        (last),
    .fin_busy    (fin_busy),
    .frame_start (frame_start),
    .frame       (frame)
  );

  pfs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (fr.tally),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  pfs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .stat     (sqrt_stat),
    .root     (root)
  );

  assign fin_busy = (state != ST_IDLE);

  // mean: (sum*256 + n/2) / n ; scaled: sum2*65536 / n
  assign d_mean    = (pfs_pkg::DIVD_W'(fr.sum) << 8) + pfs_pkg::DIVD_W'(fr.tally >> 1);
  assign d_scaled  = pfs_pkg::DIVD_W'(fr.sq) << 16;
  assign div_start = (state == ST_MEAN) || (state == ST_MEAN_WAIT && div_stat.done);
  assign div_numer = (state == ST_MEAN) ? d_mean : d_scaled;

  assign mean_sq    = pfs_pkg::RAD_W'(mean_r) * pfs_pkg::RAD_W'(mean_r);
  assign sqrt_start = (state == ST_DIFF);
  assign radicand   = (scaled > msq) ? (scaled - msq) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_HOLD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (frame_start) begin
            fr    <= frame;
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          state <= ST_MEAN_WAIT;
        end
        ST_MEAN_WAIT: begin
          if (div_stat.done) begin
            mean_r <= div_quot[pfs_pkg::F24_W-1:0];
            state  <= ST_SC_WAIT;
          end
        end
        ST_SC_WAIT: begin
          if (div_stat.done) begin
            scaled <= div_quot;
            state  <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          msq   <= mean_sq;
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          state <= ST_ROOT_WAIT;
        end
        ST_ROOT_WAIT: begin
          if (sqrt_stat.done) begin
            sd    <= root;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            mean_q8        <= mean_r;
            stddev_q8      <= sd;
            max_value      <= fr.max_v;
            min_value      <= fr.min_v;
            overload_count <= pfs_pkg::fit24(fr.ovl);
            pixel_count    <= pfs_pkg::fit24(fr.tally);
            count_overflow <= fr.ovf;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    frame_start |-> state == ST_IDLE)
    else $error("frame handed over while finisher busy");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_MEAN_WAIT || state == ST_SC_WAIT))
    else $error("divider finished outside a wait state");

  a_root_done: assert property (@(posedge clk) disable iff (rst)
    sqrt_stat.done |-> state == ST_ROOT_WAIT)
    else $error("root finished outside its wait state");

  a_unit_free: assert property (@(posedge clk) disable iff (rst)
    (div_start || sqrt_start) |-> !(div_stat.busy || sqrt_stat.busy))
    else $error("serial unit restarted while busy");

  a_load_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_HOLD)
    else $error("result loaded outside hold state");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/pfs_accum.sv
// Per-pixel front end: threshold register, squaring stage and frame accumulators.
// Depends on pfs_pkg.
`default_nettype none
module pfs_accum (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [pfs_pkg::PIX_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [pfs_pkg::PIX_W-1:0]      pixel,
  input  wire logic                           last,
  input  wire logic                           fin_busy,
  output logic                                frame_start,
  output pfs_pkg::frame_t                     frame
);

  logic                          s1_valid;
  logic                          s1_last;
  logic [pfs_pkg::PIX_W-1:0]     s1_px;
  logic [2*pfs_pkg::PIX_W-1:0]   s1_sq;
  logic [2*pfs_pkg::PIX_W-1:0]   sq_in;
  logic [pfs_pkg::PIX_W-1:0]     threshold;
  logic                          adv;
  pfs_pkg::frame_t               acc;
  pfs_pkg::frame_t               acc_next;

  assign sq_in = (2*pfs_pkg::PIX_W)'(pixel) * (2*pfs_pkg::PIX_W)'(pixel);

  // a last request waits in stage 1 until the finisher can take the frame
  assign adv         = !(s1_valid && s1_last && fin_busy);
  assign in_ready    = adv;
  assign frame_start = s1_valid && s1_last && adv;
  assign frame       = acc_next;

  always_comb begin
    acc_next = acc;
    if (acc.tally != pfs_pkg::TALLY_MAX) begin
      acc_next.sum   = acc.sum + pfs_pkg::SUM_W'(s1_px);
      acc_next.sq    = acc.sq + pfs_pkg::SQ_W'(s1_sq);
      acc_next.tally = acc.tally + pfs_pkg::COUNT_BITS'(1);
    end else begin
      acc_next.ovf = 1'b1;
    end
    if (s1_px > acc.max_v) begin
      acc_next.max_v = s1_px;
    end
    if (s1_px < acc.min_v) begin
      acc_next.min_v = s1_px;
    end
    if (s1_px >= threshold && acc.ovl != pfs_pkg::TALLY_MAX) begin
      acc_next.ovl = acc.ovl + pfs_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      acc       <= pfs_pkg::FRAME_CLEAR;
      threshold <= pfs_pkg::THR_RESET;
    end else begin
      if (cfg_write) begin
        threshold <= cfg_data;
      end
      if (adv) begin
        s1_valid <= in_valid;
        if (s1_valid) begin
          acc <= s1_last ? pfs_pkg::FRAME_CLEAR : acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px   <= pixel;
      s1_sq   <= sq_in;
      s1_last <= last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pfs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pfs_pkg.
`default_nettype none
module pfs_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [pfs_pkg::DIVD_W-1:0]      numer,
  input  wire logic [pfs_pkg::COUNT_BITS-1:0]  denom,
  output pfs_pkg::unit_stat_t                  stat,
  output logic [pfs_pkg::QUOT_W-1:0]           quot
);

  logic [pfs_pkg::COUNT_BITS-1:0] rem;
  logic [pfs_pkg::COUNT_BITS-1:0] rem_next;
  logic [pfs_pkg::COUNT_BITS-1:0] dvs;
  logic [pfs_pkg::QUOT_W-1:0]     shreg;
  logic [pfs_pkg::COUNT_BITS:0]   trial;
  logic [pfs_pkg::COUNT_BITS:0]   diff;
  logic                           ge;
  logic [pfs_pkg::QCNT_W-1:0]     cnt;
  logic                           busy;
  logic                           done;

  assign trial    = {rem, shreg[pfs_pkg::QUOT_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? diff[pfs_pkg::COUNT_BITS-1:0] : trial[pfs_pkg::COUNT_BITS-1:0];

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pfs_pkg::QCNT_W'(pfs_pkg::QUOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - pfs_pkg::QCNT_W'(1);
        end
      end
    end
  end

  // high part of the dividend is below the divisor, so it seeds the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= numer[pfs_pkg::DIVD_W-1:pfs_pkg::QUOT_W];
      shreg <= numer[pfs_pkg::QUOT_W-1:0];
      dvs   <= denom;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[pfs_pkg::QUOT_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pfs_sqrt.sv
// Digit-serial integer square root, one root bit (two radicand bits) per cycle.
// Depends on pfs_pkg.
`default_nettype none
module pfs_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pfs_pkg::RAD_W-1:0]   radicand,
  output pfs_pkg::unit_stat_t              stat,
  output logic [pfs_pkg::ROOT_W-1:0]       root
);

  logic [pfs_pkg::SREM_W-1:0]   srem;
  logic [pfs_pkg::SREM_W-1:0]   srem_next;
  logic [pfs_pkg::RAD_W-1:0]    sh;
  logic [pfs_pkg::ROOT_W-1:0]   root_r;
  logic [pfs_pkg::SREM_W+1:0]   t;
  logic [pfs_pkg::SREM_W+1:0]   trial;
  logic [pfs_pkg::SREM_W+1:0]   d;
  logic                         ge;
  logic [pfs_pkg::RCNT_W-1:0]   cnt;
  logic                         busy;
  logic                         done;

  assign t         = {srem, sh[pfs_pkg::RAD_W-1 -: 2]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign d         = t - trial;
  assign ge        = t >= trial;
  assign srem_next = ge ? d[pfs_pkg::SREM_W-1:0] : t[pfs_pkg::SREM_W-1:0];

  assign stat.busy = busy;
  assign stat.done = done;
  assign root      = root_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pfs_pkg::RCNT_W'(pfs_pkg::ROOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - pfs_pkg::RCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      srem   <= '0;
      sh     <= radicand;
      root_r <= '0;
    end else if (busy) begin
      srem   <= srem_next;
      sh     <= {sh[pfs_pkg::RAD_W-3:0], 2'b00};
      root_r <= {root_r[pfs_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: dv/pixel_frame_statistics_tb.sv
// Testbench for pixel_frame_statistics: directed and random frames against a built-in predictor.
// Depends on pfs_pkg and the pixel_frame_statistics RTL; reads no files.
`timescale 1ns / 1ps

module pixel_frame_statistics_tb;

  localparam int DRAIN_CYCLES = 160;
  localparam int IDLE_LIMIT   = 4000;

  typedef struct packed {
    logic [pfs_pkg::F24_W-1:0] mean_q8;
    logic [pfs_pkg::F24_W-1:0] stddev_q8;
    logic [pfs_pkg::PIX_W-1:0] max_value;
    logic [pfs_pkg::PIX_W-1:0] min_value;
    logic [pfs_pkg::F24_W-1:0] overload_count;
    logic [pfs_pkg::F24_W-1:0] pixel_count;
    logic                      count_overflow;
  } frame_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [pfs_pkg::PIX_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [pfs_pkg::PIX_W-1:0] pixel = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [pfs_pkg::F24_W-1:0] mean_q8, stddev_q8, overload_count, pixel_count;
  logic [pfs_pkg::PIX_W-1:0] max_value, min_value;
  logic count_overflow;

  pixel_frame_statistics dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel          (pixel),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mean_q8        (mean_q8),
    .stddev_q8      (stddev_q8),
    .max_value      (max_value),
    .min_value      (min_value),
    .overload_count (overload_count),
    .pixel_count    (pixel_count),
    .count_overflow (count_overflow)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [pfs_pkg::PIX_W-1:0]      thr_shadow = pfs_pkg::THR_RESET;
  logic [63:0]                    frame_sum, frame_sq;
  logic [pfs_pkg::PIX_W-1:0]      frame_max, frame_min;
  logic [pfs_pkg::COUNT_BITS-1:0] frame_ovl, frame_cnt;
  logic                           frame_ovf;

  frame_stats_t pending_stats[$];
  frame_stats_t want;
  int errors = 0;
  int burst_left = 0;
  int ready_hold = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] root_trunc(input logic [63:0] v);
    logic [63:0] res, trial;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  task automatic clear_frame_stats();
    frame_sum = '0;
    frame_sq  = '0;
    frame_max = '0;
    frame_min = pfs_pkg::PIX_MAX;
    frame_ovl = '0;
    frame_cnt = '0;
    frame_ovf = 1'b0;
  endtask

  task automatic accumulate_pixel(input logic [pfs_pkg::PIX_W-1:0] p, input logic l);
    logic [63:0] n, mean, scaled, msq, variance, sd;
    frame_stats_t r;
    if (frame_cnt < pfs_pkg::TALLY_MAX) begin
      frame_sum += 64'(p);
      frame_sq  += 64'(p) * 64'(p);
      frame_cnt++;
    end else begin
      frame_ovf = 1'b1;
    end
    if (p > frame_max) frame_max = p;
    if (p < frame_min) frame_min = p;
    if (p >= thr_shadow && frame_ovl < pfs_pkg::TALLY_MAX) frame_ovl++;
    if (l) begin
      n = 64'(frame_cnt);
      mean = (frame_sum * 256 + n / 2) / n;
      scaled = (frame_sq / n) * 65536 + ((frame_sq % n) * 65536) / n;
      msq = mean * mean;
      variance = (scaled > msq) ? scaled - msq : 64'd0;
      sd = root_trunc(variance);
      r.mean_q8        = mean[pfs_pkg::F24_W-1:0];
      r.stddev_q8      = sd[pfs_pkg::F24_W-1:0];
      r.max_value      = frame_max;
      r.min_value      = frame_min;
      r.overload_count = pfs_pkg::F24_W'(frame_ovl);
      r.pixel_count    = pfs_pkg::F24_W'(frame_cnt);
      r.count_overflow = frame_ovf;
      pending_stats.push_back(r);
      clear_frame_stats();
    end
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pixel(input logic [pfs_pkg::PIX_W-1:0] p, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pixel    <= p;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_pixel(p, l);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [pfs_pkg::PIX_W-1:0] v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    thr_shadow = v;
  endtask

  task automatic check_field(input string name, input logic [pfs_pkg::F24_W-1:0] exp_v,
                             input logic [pfs_pkg::F24_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // default threshold: extremes, threshold boundary, clamped variance, constant frame
  task automatic test_default_threshold();
    send_pixel(16'd0, 1'b1);
    send_pixel(16'd65535, 1'b1);
    send_pixel(16'd65529, 1'b0);
    send_pixel(16'd65530, 1'b0);
    send_pixel(16'd65531, 1'b1);
    send_pixel(16'd65535, 1'b0);
    send_pixel(16'd65535, 1'b0);
    send_pixel(16'd65534, 1'b1);
    send_pixel(16'd0, 1'b0);
    send_pixel(16'd65535, 1'b1);
    repeat (3) send_pixel(16'd12345, 1'b0);
    send_pixel(16'd12345, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    set_threshold(16'd0);
    send_pixel(16'd0, 1'b0);
    send_pixel(16'd7, 1'b0);
    send_pixel(16'd65535, 1'b1);
    set_threshold(16'd65535);
    send_pixel(16'd65534, 1'b0);
    send_pixel(16'd65535, 1'b0);
    send_pixel(16'd65535, 1'b1);
    set_threshold(16'd1);
    send_pixel(16'd0, 1'b0);
    send_pixel(16'd1, 1'b1);
  endtask

  task automatic random_frames(input int target);
    int sent, len, style, base;
    logic [pfs_pkg::PIX_W-1:0] p;
    sent = 0;
    while (sent < target) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 300) : $urandom_range(1, 32);
      if (len > target - sent) len = target - sent;
      style = $urandom_range(0, 5);
      base  = $urandom_range(0, 65535);
      for (int i = 0; i < len; i++) begin
        case (style)
          0: p = 16'($urandom_range(0, 65535));
          1: p = 16'(base + $urandom_range(0, 7));
          2: p = 16'($urandom_range(65500, 65535));
          3: p = 16'(base);
          4: p = $urandom_range(0, 1) ? pfs_pkg::PIX_MAX : 16'd0;
          default: p = 16'(int'(thr_shadow) + int'($urandom_range(0, 4)) - 2);
        endcase
        send_pixel(p, i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    set_threshold(16'($urandom_range(0, 65535)));
    random_frames(216);
    set_threshold(16'd65530);
    random_frames(216);
    set_threshold(16'd32768);
    random_frames(216);
    set_threshold(16'($urandom_range(0, 255)));
    random_frames(216);
    set_threshold(16'($urandom_range(65280, 65535)));
    random_frames(216);
  endtask

  // receiver: long open stretches, short stalls, choppy ready
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      case ($urandom_range(0, 7))
        0: begin
          out_ready <= 1'b1;
          ready_hold = 200;
        end
        1, 2: begin
          out_ready <= 1'b0;
          ready_hold = $urandom_range(1, 40);
        end
        3: begin
          out_ready <= 1'b0;
          ready_hold = $urandom_range(0, 2);
        end
        default: begin
          out_ready <= 1'b1;
          ready_hold = $urandom_range(0, 8);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: result with no request pending: mean %0d stddev %0d count %0d",
                 $time, mean_q8, stddev_q8, pixel_count);
        errors++;
      end else begin
        want = pending_stats.pop_front();
        check_field("mean_q8", want.mean_q8, mean_q8);
        check_field("stddev_q8", want.stddev_q8, stddev_q8);
        check_field("max_value", 24'(want.max_value), 24'(max_value));
        check_field("min_value", 24'(want.min_value), 24'(min_value));
        check_field("overload_count", want.overload_count, overload_count);
        check_field("pixel_count", want.pixel_count, pixel_count);
        check_field("count_overflow", 24'(want.count_overflow), 24'(count_overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    clear_frame_stats();
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_default_threshold();
    test_threshold_extremes();
    test_random_traffic();
    wait_drained();
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pfs_pkg.sv
rtl/core/pfs_accum.sv
rtl/core/pfs_div.sv
rtl/core/pfs_sqrt.sv
rtl/core/pixel_frame_statistics.sv
dv/pixel_frame_statistics_tb.sv
